// ===== rtl/ptw_pkg.sv =====
`timescale 1ns / 1ps

package ptw_pkg;

  localparam int ENTRY_IDX_W = 9;
  localparam int ENTRY_W     = 64;
  localparam int VA_W        = 48;
  localparam int PA_W        = 52;
  localparam int OP_W        = 2;
  localparam int ROOT_W      = 6;
  localparam int SIZE_W      = 2;

  localparam int PRESENT_BIT = 0;
  localparam int HUGE_BIT    = 7;

  localparam logic [SIZE_W-1:0] PAGE_4K = 2'd0;
  localparam logic [SIZE_W-1:0] PAGE_2M = 2'd1;
  localparam logic [SIZE_W-1:0] PAGE_1G = 2'd2;

  localparam logic [1:0] LVL_TOP  = 2'd0;
  localparam logic [1:0] LVL_1G   = 2'd1;
  localparam logic [1:0] LVL_2M   = 2'd2;
  localparam logic [1:0] LVL_LEAF = 2'd3;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE     = 2'd0,
    OP_TRANSLATE = 2'd1,
    OP_UNMAP     = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_ISSUE,
    ST_EVAL,
    ST_FAIL
  } state_t;

  typedef struct packed {
    logic                valid;
    logic                found;
    logic [PA_W-1:0]     mapped_addr;
    logic [ENTRY_W-1:0]  entry_flags;
    logic [SIZE_W-1:0]   leaf_size;
  } ptw_result_t;

  // Virtual-address slice that indexes the table at a given walk level.
  function automatic logic [ENTRY_IDX_W-1:0] level_index(input logic [VA_W-1:0] va,
                                                         input logic [1:0] lvl);
    logic [ENTRY_IDX_W-1:0] idx;
    unique case (lvl)
      LVL_TOP:  idx = va[47:39];
      LVL_1G:   idx = va[38:30];
      LVL_2M:   idx = va[29:21];
      default:  idx = va[20:12];
    endcase
    return idx;
  endfunction

endpackage

// ===== rtl/ptw_store.sv =====
`timescale 1ns / 1ps

module ptw_store import ptw_pkg::*; #(
  parameter int DEPTH  = 32768,
  parameter int ADDR_W = 15
) (
  input  logic               clk,
  input  logic [ADDR_W-1:0]  addr,
  input  logic               we,
  input  logic [ENTRY_W-1:0] wdata,
  input  logic               re,
  output logic [ENTRY_W-1:0] rdata
);

  logic [ENTRY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== rtl/ptw_walk.sv =====
`timescale 1ns / 1ps

module ptw_walk import ptw_pkg::*; #(
  parameter int TABLE_FRAMES = 64,
  parameter int FRAME_W      = 6,
  parameter int ADDR_W       = 15
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [OP_W-1:0]        operation,
  input  logic [ROOT_W-1:0]      table_frame,
  input  logic [ENTRY_IDX_W-1:0] entry_index,
  input  logic [ENTRY_W-1:0]     entry_value,
  input  logic [VA_W-1:0]        lookup_addr,
  input  logic [ROOT_W-1:0]      unmap_root_frame,
  input  logic [ROOT_W-1:0]      root_frame,
  output ptw_result_t            result,
  output logic [ADDR_W-1:0]      mem_addr,
  output logic                   mem_we,
  output logic [ENTRY_W-1:0]     mem_wdata,
  output logic                   mem_re,
  input  logic [ENTRY_W-1:0]     mem_rdata
);

  localparam int DEPTH = TABLE_FRAMES * (2 ** ENTRY_IDX_W);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

  state_t                 state, state_next;
  logic [OP_W-1:0]        op_q;
  logic [VA_W-1:0]        va_q;
  logic [ROOT_W-1:0]      root_q;
  logic [ROOT_W-1:0]      wr_frame_q;
  logic [ENTRY_IDX_W-1:0] wr_idx_q;
  logic [ENTRY_W-1:0]     wr_val_q;
  logic [1:0]             lvl, lvl_next;
  logic [ADDR_W-1:0]      leaf_addr, leaf_addr_next;
  logic [ADDR_W-1:0]      clr_addr;

  logic                   accept;
  logic                   present;
  logic                   huge;
  logic [39:0]            next_frame;
  logic                   next_ok;
  logic [1:0]             lvl_inc;
  logic [ADDR_W-1:0]      next_addr;
  logic [ADDR_W-1:0]      root_addr;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  assign present    = mem_rdata[PRESENT_BIT];
  assign huge       = mem_rdata[HUGE_BIT] && ((lvl == LVL_1G) || (lvl == LVL_2M));
  assign next_frame = mem_rdata[51:12];
  assign next_ok    = (next_frame < 40'(TABLE_FRAMES));
  assign lvl_inc    = lvl + 2'd1;
  assign next_addr  = {next_frame[FRAME_W-1:0], level_index(va_q, lvl_inc)};
  assign root_addr  = {FRAME_W'(root_q), level_index(va_q, LVL_TOP)};

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q       <= operation;
      va_q       <= lookup_addr;
      root_q     <= (op_t'(operation) == OP_TRANSLATE) ? root_frame : unmap_root_frame;
      wr_frame_q <= table_frame;
      wr_idx_q   <= entry_index;
      wr_val_q   <= entry_value;
    end
    lvl       <= lvl_next;
    leaf_addr <= leaf_addr_next;
  end

  always_comb begin
    state_next     = state;
    lvl_next       = lvl;
    leaf_addr_next = leaf_addr;
    mem_addr       = '0;
    mem_we         = 1'b0;
    mem_wdata      = '0;
    mem_re         = 1'b0;
    result         = '0;

    unique case (state)
      ST_CLEAR: begin
        mem_addr = clr_addr;
        mem_we   = 1'b1;
        if (clr_addr == LAST_ADDR) begin
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (accept) begin
          lvl_next = LVL_TOP;
          unique case (op_t'(operation))
            OP_WRITE:     state_next = ST_WRITE;
            OP_TRANSLATE: state_next = ST_ISSUE;
            OP_UNMAP:     state_next = ST_ISSUE;
            default:      state_next = ST_FAIL;
          endcase
        end
      end

      ST_WRITE: begin
        state_next   = ST_IDLE;
        result.valid = 1'b1;
        if (32'(wr_frame_q) < TABLE_FRAMES) begin
          mem_addr     = {FRAME_W'(wr_frame_q), wr_idx_q};
          mem_we       = 1'b1;
          mem_wdata    = wr_val_q;
          result.found = 1'b1;
        end
      end

      ST_ISSUE: begin
        if (32'(root_q) < TABLE_FRAMES) begin
          mem_addr       = root_addr;
          mem_re         = 1'b1;
          leaf_addr_next = root_addr;
          state_next     = ST_EVAL;
        end else begin
          result.valid = 1'b1;
          state_next   = ST_IDLE;
        end
      end

      ST_EVAL: begin
        if (!present) begin
          result.valid = 1'b1;
          state_next   = ST_IDLE;
        end else if (lvl == LVL_LEAF) begin
          result.valid = 1'b1;
          result.found = 1'b1;
          state_next   = ST_IDLE;
          if (op_t'(op_q) == OP_UNMAP) begin
            // The leaf slot is still held from the read that fetched it.
            mem_addr           = leaf_addr;
            mem_we             = 1'b1;
            result.mapped_addr = {mem_rdata[51:12], 12'd0};
          end else begin
            result.mapped_addr = {mem_rdata[51:12], va_q[11:0]};
            result.entry_flags = {mem_rdata[63:52], 40'd0, mem_rdata[11:0]};
            result.leaf_size   = PAGE_4K;
          end
        end else if (huge) begin
          result.valid = 1'b1;
          state_next   = ST_IDLE;
          if (op_t'(op_q) == OP_TRANSLATE) begin
            result.found       = 1'b1;
            result.entry_flags = {mem_rdata[63:52], 40'd0, mem_rdata[11:0]};
            if (lvl == LVL_1G) begin
              result.mapped_addr = {mem_rdata[51:30], va_q[29:0]};
              result.leaf_size   = PAGE_1G;
            end else begin
              result.mapped_addr = {mem_rdata[51:21], va_q[20:0]};
              result.leaf_size   = PAGE_2M;
            end
          end
        end else if (next_ok) begin
          mem_addr       = next_addr;
          mem_re         = 1'b1;
          leaf_addr_next = next_addr;
          lvl_next       = lvl_inc;
        end else begin
          result.valid = 1'b1;
          state_next   = ST_IDLE;
        end
      end

      ST_FAIL: begin
        result.valid = 1'b1;
        state_next   = ST_IDLE;
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTH
  a_port_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(mem_we && mem_re))
    else $error("table store read and written in the same cycle");

  a_eval_has_data: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EVAL) |-> $past(mem_re))
    else $error("entry evaluated without a read in the previous cycle");

  a_no_result_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !result.valid)
    else $error("result produced during the clearing pass");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("accepted word did not make the block busy");
`endif

endmodule

// ===== rtl/four_level_page_table_walker.sv =====
`timescale 1ns / 1ps

// A write word is written in ST_WRITE, whose result is registered onto done; a translate or
// unmap word reads up to 4 table levels in ST_ISSUE and ST_EVAL, one store access a cycle.
// Busy stays high from acceptance until the result is produced, so no new word is taken meanwhile.
// Results are strobed by done for one cycle; the receiver cannot stall.
// After reset the store is cleared one entry a cycle (all TABLE_FRAMES * 512 entries, 32768 by
// default) with busy high; the root-frame register resets to 0 and can be written meanwhile.
module four_level_page_table_walker import ptw_pkg::*; #(
  parameter int TABLE_FRAMES = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [OP_W-1:0]        operation,
  input  logic [ROOT_W-1:0]      table_frame,
  input  logic [ENTRY_IDX_W-1:0] entry_index,
  input  logic [ENTRY_W-1:0]     entry_value,
  input  logic [VA_W-1:0]        lookup_addr,
  input  logic [ROOT_W-1:0]      unmap_root_frame,
  input  logic                   cfg_write,
  input  logic [ROOT_W-1:0]      cfg_data,
  output logic                   done,
  output logic                   found,
  output logic [PA_W-1:0]        mapped_addr,
  output logic [ENTRY_W-1:0]     entry_flags,
  output logic [SIZE_W-1:0]      leaf_size
);

  localparam int FRAME_W = (TABLE_FRAMES > 1) ? $clog2(TABLE_FRAMES) : 1;
  localparam int ADDR_W  = FRAME_W + ENTRY_IDX_W;
  localparam int DEPTH   = TABLE_FRAMES * (2 ** ENTRY_IDX_W);

  logic [ROOT_W-1:0]  translate_root_frame;
  ptw_result_t        result;
  logic [ADDR_W-1:0]  mem_addr;
  logic               mem_we;
  logic [ENTRY_W-1:0] mem_wdata;
  logic               mem_re;
  logic [ENTRY_W-1:0] mem_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      translate_root_frame <= '0;
      done                 <= 1'b0;
    end else begin
      if (cfg_write) begin
        translate_root_frame <= cfg_data;
      end
      done <= result.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (result.valid) begin
      found       <= result.found;
      mapped_addr <= result.mapped_addr;
      entry_flags <= result.entry_flags;
      leaf_size   <= result.leaf_size;
    end
  end

  ptw_walk #(
    .TABLE_FRAMES (TABLE_FRAMES),
    .FRAME_W      (FRAME_W),
    .ADDR_W       (ADDR_W)
  ) u_walk (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .operation        (operation),
    .table_frame      (table_frame),
    .entry_index      (entry_index),
    .entry_value      (entry_value),
    .lookup_addr      (lookup_addr),
    .unmap_root_frame (unmap_root_frame),
    .root_frame       (translate_root_frame),
    .result           (result),
    .mem_addr         (mem_addr),
    .mem_we           (mem_we),
    .mem_wdata        (mem_wdata),
    .mem_re           (mem_re),
    .mem_rdata        (mem_rdata)
  );

  ptw_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk   (clk),
    .addr  (mem_addr),
    .we    (mem_we),
    .wdata (mem_wdata),
    .re    (mem_re),
    .rdata (mem_rdata)
  );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import ptw_pkg::*;

  localparam int TABLE_FRAMES = 64;
  localparam int QUIET_LIMIT = 100000;
  localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]        op;
    logic [ROOT_W-1:0]      tf;
    logic [ENTRY_IDX_W-1:0] ei;
    logic [ENTRY_W-1:0]     ev;
    logic [VA_W-1:0]        va;
    logic [ROOT_W-1:0]      ur;
  } walk_req_t;

  typedef struct packed {
    logic               found;
    logic [PA_W-1:0]    mapped_addr;
    logic [ENTRY_W-1:0] entry_flags;
    logic [SIZE_W-1:0]  leaf_size;
  } walk_word_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   start = 1'b0;
  logic                   busy;
  logic [OP_W-1:0]        operation = '0;
  logic [ROOT_W-1:0]      table_frame = '0;
  logic [ENTRY_IDX_W-1:0] entry_index = '0;
  logic [ENTRY_W-1:0]     entry_value = '0;
  logic [VA_W-1:0]        lookup_addr = '0;
  logic [ROOT_W-1:0]      unmap_root_frame = '0;
  logic                   cfg_write = 1'b0;
  logic [ROOT_W-1:0]      cfg_data = '0;
  logic                   done;
  logic                   found;
  logic [PA_W-1:0]        mapped_addr;
  logic [ENTRY_W-1:0]     entry_flags;
  logic [SIZE_W-1:0]      leaf_size;

  walk_req_t  pend_q[$];
  walk_word_t walk_q[$];
  logic [ENTRY_W-1:0] pt_mem [0:TABLE_FRAMES*512-1] = '{default: '0};
  logic [ROOT_W-1:0]  root_model = '0;
  logic [ROOT_W-1:0]  cur_root = '0;
  logic took = 1'b0;
  int   n_queued = 0;
  int   n_accepted = 0;
  int   n_errors = 0;
  int   quiet = 0;
  int   gap_left = 0;
  int   burst_left = 1;

  four_level_page_table_walker i_dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .operation        (operation),
    .table_frame      (table_frame),
    .entry_index      (entry_index),
    .entry_value      (entry_value),
    .lookup_addr      (lookup_addr),
    .unmap_root_frame (unmap_root_frame),
    .cfg_write        (cfg_write),
    .cfg_data         (cfg_data),
    .done             (done),
    .found            (found),
    .mapped_addr      (mapped_addr),
    .entry_flags      (entry_flags),
    .leaf_size        (leaf_size)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Reads one table entry; false when the frame is outside the store or the entry is absent.
  function automatic logic fetch(input logic [39:0] frame, input logic [8:0] idx,
                                 output logic [63:0] e, output logic [14:0] slot);
    e = '0;
    slot = {frame[5:0], idx};
    if (frame >= 40'(TABLE_FRAMES)) return 1'b0;
    e = pt_mem[slot];
    return e[PRESENT_BIT];
  endfunction

  function automatic walk_word_t walk_model(input walk_req_t rq);
    walk_word_t w;
    logic [63:0] e;
    logic [14:0] slot;
    logic ok;
    w = '0;
    case (rq.op)
      OP_WRITE: begin
        pt_mem[{rq.tf, rq.ei}] = rq.ev;
        w.found = 1'b1;
      end
      OP_TRANSLATE: begin
        ok = fetch({34'd0, root_model}, rq.va[47:39], e, slot);
        if (ok) ok = fetch(e[51:12], rq.va[38:30], e, slot);
        if (ok && e[HUGE_BIT]) begin
          w.found = 1'b1;
          w.leaf_size = PAGE_1G;
          w.mapped_addr = {e[51:30], rq.va[29:0]};
        end else if (ok) begin
          ok = fetch(e[51:12], rq.va[29:21], e, slot);
          if (ok && e[HUGE_BIT]) begin
            w.found = 1'b1;
            w.leaf_size = PAGE_2M;
            w.mapped_addr = {e[51:21], rq.va[20:0]};
          end else if (ok) begin
            ok = fetch(e[51:12], rq.va[20:12], e, slot);
            if (ok) begin
              w.found = 1'b1;
              w.leaf_size = PAGE_4K;
              w.mapped_addr = {e[51:12], rq.va[11:0]};
            end
          end
        end
        if (w.found) w.entry_flags = {e[63:52], 40'd0, e[11:0]};
      end
      OP_UNMAP: begin
        // The top-level huge bit is ignored; huge entries further down refuse the unmap.
        ok = fetch({34'd0, rq.ur}, rq.va[47:39], e, slot);
        if (ok) ok = fetch(e[51:12], rq.va[38:30], e, slot);
        ok = ok && !e[HUGE_BIT];
        if (ok) ok = fetch(e[51:12], rq.va[29:21], e, slot);
        ok = ok && !e[HUGE_BIT];
        if (ok) ok = fetch(e[51:12], rq.va[20:12], e, slot);
        if (ok) begin
          w.found = 1'b1;
          w.mapped_addr = {e[51:12], 12'd0};
          pt_mem[slot] = '0;
        end
      end
      default: ;
    endcase
    return w;
  endfunction

  task automatic report(input string what, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      n_errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
    end
  endtask

  always @(negedge clk) begin : drive_p
    walk_req_t nxt;
    logic drive;
    drive = 1'b0;
    if (rst) begin
      start <= 1'b0;
    end else if (!(start && !took)) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
      end else if (pend_q.size() != 0) begin
        nxt = pend_q.pop_front();
        drive = 1'b1;
        operation <= nxt.op;
        table_frame <= nxt.tf;
        entry_index <= nxt.ei;
        entry_value <= nxt.ev;
        lookup_addr <= nxt.va;
        unmap_root_frame <= nxt.ur;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 16);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
      start <= drive;
    end
  end

  always @(posedge clk) begin : check_p
    walk_word_t want;
    walk_req_t  rq;
    if (rst) begin
      took <= 1'b0;
      root_model <= '0;
    end else begin
      took <= start && !busy;
      if (done) begin
        if (walk_q.size() == 0) begin
          n_errors++;
          $display("%0t: result word with none expected, actual found %b addr %h", $time,
                   found, mapped_addr);
        end else begin
          want = walk_q.pop_front();
          report("found", 64'(want.found), 64'(found));
          report("mapped_addr", 64'(want.mapped_addr), 64'(mapped_addr));
          report("entry_flags", want.entry_flags, entry_flags);
          report("leaf_size", 64'(want.leaf_size), 64'(leaf_size));
        end
      end
      if (start && !busy) begin
        rq = '{op: operation, tf: table_frame, ei: entry_index, ev: entry_value,
               va: lookup_addr, ur: unmap_root_frame};
        walk_q.push_back(walk_model(rq));
        n_accepted <= n_accepted + 1;
      end
      if (cfg_write) root_model <= cfg_data;
    end
    // The post-reset store clear keeps busy high for the whole clearing pass, which QUIET_LIMIT outlasts.
    if (done || (start && !busy)) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  task automatic add_item(input logic [OP_W-1:0] op, input logic [5:0] tf, input logic [8:0] ei,
                          input logic [63:0] ev, input logic [47:0] va, input logic [5:0] ur);
    pend_q.push_back('{op: op, tf: tf, ei: ei, ev: ev, va: va, ur: ur});
    n_queued++;
  endtask

  task automatic put_entry(input logic [5:0] frame, input logic [8:0] idx,
                           input logic [63:0] value);
    add_item(OP_WRITE, frame, idx, value, 48'(rnd64()), 6'($urandom));
  endtask

  task automatic translate(input logic [47:0] va);
    add_item(OP_TRANSLATE, 6'($urandom), 9'($urandom), rnd64(), va, 6'($urandom));
  endtask

  task automatic unmap(input logic [5:0] root, input logic [47:0] va);
    add_item(OP_UNMAP, 6'($urandom), 9'($urandom), rnd64(), va, root);
  endtask

  // Table pointer with random flag bits; now and then absent or pointing outside the store.
  function automatic logic [63:0] link(input logic [5:0] frame, input logic top);
    logic [63:0] e;
    e = rnd64();
    e[51:12] = ($urandom_range(0, 11) == 0) ? 40'(rnd64()) : {34'd0, frame};
    e[PRESENT_BIT] = ($urandom_range(0, 11) != 0);
    if (!top) e[HUGE_BIT] = 1'b0;
    return e;
  endfunction

  function automatic logic [63:0] leaf(input logic huge);
    logic [63:0] e;
    e = rnd64();
    e[PRESENT_BIT] = ($urandom_range(0, 11) != 0);
    if (huge) e[HUGE_BIT] = 1'b1;
    return e;
  endfunction

  // Builds a walk for a random address, then translates or unmaps around it.
  task automatic map_and_probe();
    logic [47:0] va;
    logic [47:0] probe;
    logic [5:0]  root, f1, f2, f3;
    int kind;
    int n;
    va = 48'(rnd64());
    root = ($urandom_range(0, 3) != 0) ? cur_root : 6'($urandom);
    f1 = 6'($urandom);
    f2 = 6'($urandom);
    f3 = 6'($urandom);
    kind = $urandom_range(0, 5);
    put_entry(root, va[47:39], link(f1, 1'b1));
    put_entry(f1, va[38:30], (kind == 5) ? leaf(1'b1) : link(f2, 1'b0));
    if (kind != 5) put_entry(f2, va[29:21], (kind == 4) ? leaf(1'b1) : link(f3, 1'b0));
    if (kind < 4) put_entry(f3, va[20:12], leaf(1'b0));
    n = $urandom_range(1, 3);
    for (int i = 0; i < n; i++) begin
      probe = va;
      if ($urandom_range(0, 3) == 0) probe[20:0] = 21'($urandom);
      else probe[11:0] = 12'($urandom);
      if ($urandom_range(0, 2) == 0) unmap(root, probe);
      else translate(probe);
    end
  endtask

  task automatic set_root(input logic [5:0] r);
    @(negedge clk);
    cfg_data <= r;
    cfg_write <= 1'b1;
    @(negedge clk);
    cfg_write <= 1'b0;
    cur_root = r;
  endtask

  task automatic drain();
    while (n_accepted != n_queued || walk_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  initial begin : stim_p
    int target;
    logic [5:0] r;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    set_root(6'd0);

    translate(48'h0);
    // The top-level entry carries the huge bit, which the walk must ignore.
    put_entry(6'd0, 9'd0, {12'hABC, 34'd0, 6'd1, 12'h081});
    put_entry(6'd1, 9'd0, 64'h0000_0000_0000_2003);
    put_entry(6'd2, 9'd0, 64'h0000_0000_0000_3001);
    put_entry(6'd3, 9'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    translate(48'h0000_0000_0ABC);
    put_entry(6'd1, 9'd1, 64'h0000_0000_0000_4001);
    put_entry(6'd4, 9'd0, 64'h8012_3456_789F_F0A3);
    translate(48'h0000_401F_FFFF);
    put_entry(6'd1, 9'd2, 64'hFFF0_0000_7FFF_F181);
    translate(48'h0000_BFFF_FFFF);
    put_entry(6'd1, 9'd3, {12'h0, 40'h40, 12'h001});
    translate(48'h0000_C000_0000);
    put_entry(6'd3, 9'd1, 64'h0000_0000_0000_5000);
    translate(48'h0000_0000_1000);
    unmap(6'd0, 48'h0000_4000_0000);
    unmap(6'd0, 48'h0000_8000_0000);
    unmap(6'd0, 48'h0000_0000_0123);
    translate(48'h0);
    unmap(6'd0, 48'h0);
    add_item(OP_RESERVED, 6'h3F, 9'h1FF, '1, '1, 6'h3F);
    put_entry(6'h3F, 9'h1FF, '1);
    translate(48'hFFFF_FFFF_FFFF);
    unmap(6'h3F, 48'hFFFF_FFFF_FFFF);
    put_entry(6'h3F, 9'h1FF, 64'h0);
    drain();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0, 4: r = 6'h3F;
        2: r = 6'd0;
        default: r = 6'($urandom);
      endcase
      set_root(r);
      target = n_queued + 140;
      while (n_queued < target) begin
        if ($urandom_range(0, 4) == 0)
          add_item(2'($urandom), 6'($urandom), 9'($urandom), rnd64(), 48'(rnd64()),
                   6'($urandom));
        else
          map_and_probe();
      end
      drain();
    end

    if (n_errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/ptw_pkg.sv
rtl/ptw_store.sv
rtl/ptw_walk.sv
rtl/four_level_page_table_walker.sv
tb/testbench.sv
